@@ src/vfc_pkg.sv @@
// ---------------------------------------------------------------------------
// vfc_pkg
// Shared types, constants and helpers of the vending sale controller.
// ---------------------------------------------------------------------------
`default_nettype none

package vfc_pkg;

  localparam int ENTRIES    = 32;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PRICE_BITS = 32;
  localparam int BTN_W      = 8;
  localparam int CODE_W     = 16;
  localparam int AMT_W      = 32;
  localparam int ITEM_W     = 5;
  localparam int ENTRY_W    = BTN_W + PRICE_BITS;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [AMT_W-1:0] AMT_MAX  = {AMT_W{1'b1}};

  typedef enum logic [2:0] {
    MODE_STEP    = 3'd0,
    MODE_ADD     = 3'd1,
    MODE_SET     = 3'd2,
    MODE_TIMEOUT = 3'd3,
    MODE_ENABLE  = 3'd4,
    MODE_WRITE   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_REQUEST  = 2'd1,
    PH_APPROVAL = 2'd2,
    PH_VEND     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    VRES_PENDING = 2'd0,
    VRES_OK      = 2'd1,
    VRES_FAIL    = 2'd2,
    VRES_IGNORED = 2'd3
  } vres_e;

  localparam logic [1:0] PAGE_KEEP    = 2'd0;
  localparam logic [1:0] PAGE_MAIN    = 2'd1;
  localparam logic [1:0] PAGE_REQUEST = 2'd2;
  localparam logic [1:0] PAGE_VEND    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PRICE,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic scan;
    logic price_latch;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic need_price;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

  // Price of a table entry that was never written.
  function automatic logic [PRICE_BITS-1:0] reset_price(input logic [IDX_W-1:0] idx);
    logic [PRICE_BITS-1:0] p;
    p = '0;
    if (int'(idx) == 0) p = PRICE_BITS'(120);
    if (int'(idx) == 1) p = PRICE_BITS'(50);
    if (int'(idx) == 2) p = PRICE_BITS'(1);
    if (int'(idx) == 3) p = PRICE_BITS'(40);
    return p;
  endfunction

endpackage

`default_nettype wire

@@ src/vfc_ram.sv @@
// ---------------------------------------------------------------------------
// vfc_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module vfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/vfc_ctrl.sv @@
// ---------------------------------------------------------------------------
// vfc_ctrl
// Sequencer: accepts a word, runs the table scan or price fetch when the word
// needs one, then commits it into the datapath once the result register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module vfc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire vfc_pkg::dp_sts_t sts_i,
  output      vfc_pkg::dp_cmd_t cmd_o
);

  import vfc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (sts_i.need_scan) begin
            state_d = ST_SCAN;
          end else if (sts_i.need_price) begin
            state_d = ST_PRICE;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_PRICE: begin
        cmd_o.price_latch = 1'b1;
        state_d           = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the result register can take the word
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q != ST_IDLE))
    else $error("vfc_ctrl: accepted word did not start processing");

  a_price_then_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PRICE) |=> (state_q == ST_FINISH))
    else $error("vfc_ctrl: price fetch not followed by commit stage");

  a_commit_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> !in_stall_o)
    else $error("vfc_ctrl: input not reopened after commit");

endmodule

`default_nettype wire

@@ src/vfc_datapath.sv @@
// ---------------------------------------------------------------------------
// vfc_datapath
// Sale state, credit, timeout flag, button/price table and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module vfc_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire vfc_pkg::dp_cmd_t             cmd_i,
  output      vfc_pkg::dp_sts_t             sts_o,
  input  wire logic [2:0]                   mode_i,
  input  wire logic                         button_valid_i,
  input  wire logic [vfc_pkg::CODE_W-1:0]   button_code_i,
  input  wire logic                         approved_i,
  input  wire logic [1:0]                   vend_result_i,
  input  wire logic [vfc_pkg::AMT_W-1:0]    amount_i,
  input  wire logic [4:0]                   entry_index_i,
  input  wire logic [vfc_pkg::BTN_W-1:0]    entry_button_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [1:0]                   sale_state_o,
  output      logic                         state_changed_o,
  output      logic                         request_valid_o,
  output      logic [vfc_pkg::AMT_W-1:0]    request_amount_o,
  output      logic [vfc_pkg::ITEM_W-1:0]   selected_item_o,
  output      logic                         dispense_valid_o,
  output      logic                         sale_success_o,
  output      logic                         sale_failure_o,
  output      logic [1:0]                   page_o,
  output      logic [vfc_pkg::AMT_W-1:0]    credit_o
);

  import vfc_pkg::*;

  // sale state
  phase_e             phase_q, phase_d;
  logic [AMT_W-1:0]   balance_q, balance_d;
  logic               tmo_q, tmo_d;
  logic [IDX_W-1:0]   item_q, item_d;
  logic [ENTRIES-1:0] ent_vld_q;

  // latched word
  logic [2:0]         mode_q;
  logic [BTN_W-1:0]   key_q;
  logic               approved_q;
  logic [1:0]         vres_q;
  logic [AMT_W-1:0]   amount_q;
  logic [4:0]         eidx_q;
  logic [BTN_W-1:0]   ebtn_q;

  // table access
  logic [IDX_W-1:0]      scan_addr_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  cmp_vld_q;
  logic [IDX_W-1:0]      raddr;
  logic [ENTRY_W-1:0]    rdata;
  logic                  ram_we;
  logic [BTN_W-1:0]      ent_btn;
  logic [PRICE_BITS-1:0] ent_price;
  logic                  scan_hit;
  logic                  found_q;
  logic [IDX_W-1:0]      match_idx_q;
  logic                  match_vend_q;
  logic [PRICE_BITS-1:0] price_q;

  // result register
  logic               out_valid_q;
  logic [1:0]         o_state_q;
  logic               o_changed_q, o_req_q, o_disp_q, o_succ_q, o_fail_q;
  logic [AMT_W-1:0]   o_req_amt_q, o_credit_q;
  logic [IDX_W-1:0]   o_item_q;
  logic [1:0]         o_page_q;

  // commit values
  logic               req_d, disp_d, succ_d, fail_d;
  logic [AMT_W-1:0]   req_amt_d;
  logic [1:0]         page_d;
  logic [AMT_W:0]     sum;
  logic [AMT_W-1:0]   price_ext;
  logic [1:0]         vres_eff;

  assign sts_o.need_scan  = (mode_i == MODE_STEP) && (phase_q == PH_IDLE) && button_valid_i;
  assign sts_o.need_price = (mode_i == MODE_STEP) && (phase_q == PH_REQUEST);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign raddr  = cmd_i.scan ? scan_addr_q : item_q;
  assign ram_we = cmd_i.commit && (mode_q == MODE_WRITE) && (int'(eidx_q) < ENTRIES);

  vfc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (eidx_q[IDX_W-1:0]),
    .wdata_i ({ebtn_q, amount_q[PRICE_BITS-1:0]}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // an entry never written reads as its reset contents
  assign ent_btn   = ent_vld_q[rd_idx_q] ? rdata[ENTRY_W-1 -: BTN_W] : BTN_W'(rd_idx_q);
  assign ent_price = ent_vld_q[rd_idx_q] ? rdata[PRICE_BITS-1:0] : reset_price(rd_idx_q);

  assign scan_hit        = cmp_vld_q && (ent_btn == key_q);
  assign sts_o.scan_done = cmp_vld_q && (scan_hit || (rd_idx_q == LAST_IDX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= raddr;
    if (cmd_i.accept) begin
      mode_q      <= mode_i;
      key_q       <= button_code_i[BTN_W-1:0];
      approved_q  <= approved_i;
      vres_q      <= vend_result_i;
      amount_q    <= amount_i;
      eidx_q      <= entry_index_i;
      ebtn_q      <= entry_button_i;
      scan_addr_q <= '0;
      found_q     <= 1'b0;
    end
    if (cmd_i.scan) begin
      scan_addr_q <= scan_addr_q + IDX_W'(1);
      // first match wins: the scan stops on it
      if (scan_hit) begin
        found_q      <= 1'b1;
        match_idx_q  <= rd_idx_q;
        match_vend_q <= balance_q >= AMT_W'(ent_price);
      end
    end
    if (cmd_i.price_latch) begin
      price_q <= ent_price;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    balance_d = balance_q;
    tmo_d     = tmo_q;
    item_d    = item_q;
    req_d     = 1'b0;
    req_amt_d = '0;
    disp_d    = 1'b0;
    succ_d    = 1'b0;
    fail_d    = 1'b0;
    page_d    = PAGE_KEEP;
    sum       = {1'b0, balance_q} + {1'b0, amount_q};
    price_ext = AMT_W'(price_q);
    vres_eff  = tmo_q ? VRES_FAIL : vres_q;
    case (mode_q)
      MODE_STEP: begin
        case (phase_q)
          PH_IDLE: begin
            if (found_q) begin
              item_d  = match_idx_q;
              phase_d = match_vend_q ? PH_VEND : PH_REQUEST;
            end
          end
          PH_REQUEST: begin
            req_amt_d = (price_ext > balance_q) ? (price_ext - balance_q) : '0;
            req_d     = 1'b1;
            page_d    = PAGE_REQUEST;
            phase_d   = PH_APPROVAL;
          end
          PH_APPROVAL: begin
            if (approved_q) begin
              page_d  = PAGE_VEND;
              disp_d  = 1'b1;
              phase_d = PH_VEND;
            end else if (tmo_q) begin
              tmo_d   = 1'b0;
              page_d  = PAGE_MAIN;
              phase_d = PH_IDLE;
            end
          end
          PH_VEND: begin
            // a pending timeout is consumed and acts as a fail report
            tmo_d = 1'b0;
            if (vres_eff == VRES_OK) begin
              balance_d = '0;
              succ_d    = 1'b1;
              page_d    = PAGE_MAIN;
              phase_d   = PH_IDLE;
            end else if (vres_eff == VRES_FAIL) begin
              fail_d  = 1'b1;
              page_d  = PAGE_MAIN;
              phase_d = PH_IDLE;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
      MODE_ADD: begin
        balance_d = sum[AMT_W] ? AMT_MAX : sum[AMT_W-1:0];
      end
      MODE_SET: begin
        balance_d = amount_q;
      end
      MODE_TIMEOUT: begin
        tmo_d = 1'b1;
      end
      MODE_ENABLE: begin
        phase_d = PH_IDLE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      balance_q   <= '0;
      tmo_q       <= 1'b0;
      item_q      <= '0;
      ent_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        phase_q     <= phase_d;
        balance_q   <= balance_d;
        tmo_q       <= tmo_d;
        item_q      <= item_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (ram_we) begin
        ent_vld_q[eidx_q[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      o_state_q   <= phase_d;
      o_changed_q <= phase_d != phase_q;
      o_req_q     <= req_d;
      o_req_amt_q <= req_amt_d;
      o_item_q    <= item_d;
      o_disp_q    <= disp_d;
      o_succ_q    <= succ_d;
      o_fail_q    <= fail_d;
      o_page_q    <= page_d;
      o_credit_q  <= balance_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sale_state_o     = o_state_q;
  assign state_changed_o  = o_changed_q;
  assign request_valid_o  = o_req_q;
  assign request_amount_o = o_req_amt_q;
  assign selected_item_o  = ITEM_W'(o_item_q);
  assign dispense_valid_o = o_disp_q;
  assign sale_success_o   = o_succ_q;
  assign sale_failure_o   = o_fail_q;
  assign page_o           = o_page_q;
  assign credit_o         = o_credit_q;

  a_request_to_approval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_req_q) |-> (o_state_q == PH_APPROVAL))
    else $error("vfc_datapath: request issued outside awaiting approval");

  a_dispense_in_vend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_disp_q) |-> (o_state_q == PH_VEND))
    else $error("vfc_datapath: dispense issued outside vending");

  a_success_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_succ_q) |-> ((o_credit_q == '0) && (o_state_q == PH_IDLE)))
    else $error("vfc_datapath: sale success with credit left");

endmodule

`default_nettype wire

@@ src/vend_flow_controller_core.sv @@
// ---------------------------------------------------------------------------
// vend_flow_controller_core
// Vending sale controller: credit, cashless request, approval, dispense.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one word per sale event:
//   a mode plus button, approval, vend result, amount and table entry fields.
//   Output channel (out_valid_o / out_stall_i) returns one result word per
//   input word, in order.
//   Processing, from the accepting edge to result valid:
//     - credit, timeout, enable, table write and other steps: straight to commit
//     - step that asks cashless for a price: one table read, then commit
//     - step in idle with a button: a scan of up to ENTRIES entries (32), one table
//       entry compared per cycle through the single table read port, then commit
//   One word is processed at a time; the next word is taken the cycle after
//   commit.
//   Reset: sale state idle, credit zero, timeout cleared, table back to its
//   default buttons and prices (tracked by per-entry valid bits, no sweep).
//   Receiver stall: the result word holds; a following word is accepted and
//   processed but waits before commit until the result register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module vend_flow_controller_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [2:0]                   mode_i,
  input  wire logic                         button_valid_i,
  input  wire logic [vfc_pkg::CODE_W-1:0]   button_code_i,
  input  wire logic                         approved_i,
  input  wire logic [1:0]                   vend_result_i,
  input  wire logic [vfc_pkg::AMT_W-1:0]    amount_i,
  input  wire logic [4:0]                   entry_index_i,
  input  wire logic [vfc_pkg::BTN_W-1:0]    entry_button_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [1:0]                   sale_state_o,
  output      logic                         state_changed_o,
  output      logic                         request_valid_o,
  output      logic [vfc_pkg::AMT_W-1:0]    request_amount_o,
  output      logic [vfc_pkg::ITEM_W-1:0]   selected_item_o,
  output      logic                         dispense_valid_o,
  output      logic                         sale_success_o,
  output      logic                         sale_failure_o,
  output      logic [1:0]                   page_o,
  output      logic [vfc_pkg::AMT_W-1:0]    credit_o
);

  import vfc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  vfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vfc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (mode_i),
    .button_valid_i   (button_valid_i),
    .button_code_i    (button_code_i),
    .approved_i       (approved_i),
    .vend_result_i    (vend_result_i),
    .amount_i         (amount_i),
    .entry_index_i    (entry_index_i),
    .entry_button_i   (entry_button_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sale_state_o     (sale_state_o),
    .state_changed_o  (state_changed_o),
    .request_valid_o  (request_valid_o),
    .request_amount_o (request_amount_o),
    .selected_item_o  (selected_item_o),
    .dispense_valid_o (dispense_valid_o),
    .sale_success_o   (sale_success_o),
    .sale_failure_o   (sale_failure_o),
    .page_o           (page_o),
    .credit_o         (credit_o)
  );

endmodule

`default_nettype wire
